### rtl/bfns_pkg.sv
// ----------------------------------------------------------------------------
// bfns_pkg
// Shared widths, reset values and operation codes for the bitmap search block.
// ----------------------------------------------------------------------------
package bfns_pkg;

   // Field widths of the request, response and configuration ports.
   localparam int MODE_W  = 3;
   localparam int INDEX_W = 10;
   localparam int LIMIT_W = 11;

   // Width of a word's base flag index while scanning; holds a limit plus one word.
   localparam int BASE_W = LIMIT_W + 1;

   // Default geometry of the bitmap.
   localparam int DEF_MAX_BITS  = 1024;
   localparam int DEF_WORD_BITS = 32;

   // Reset value of the flags-in-use register.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   // Largest value the flags-in-use register can hold.
   localparam int LIMIT_MAX = (1 << LIMIT_W) - 1;

   // Operation codes carried by a request.
   typedef enum logic [MODE_W-1:0] {
      MODE_SET        = 3'd0,
      MODE_CLEAR      = 3'd1,
      MODE_TEST       = 3'd2,
      MODE_ALL_SET    = 3'd3,
      MODE_NEXT_CLEAR = 3'd4,
      MODE_NEXT_SET   = 3'd5
   } mode_type;

endpackage

### rtl/bfns_word_scan.sv
// ----------------------------------------------------------------------------
// bfns_word_scan
// Finds the lowest flag of one bitmap word that matches the wanted value and
// lies inside the window from a start offset up to the flags in use.
// ----------------------------------------------------------------------------
module bfns_word_scan
   import bfns_pkg::*;
#(
   parameter int WORD_BITS = DEF_WORD_BITS,
   parameter int OFF_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic                 find_set,
   input  logic [OFF_W-1:0]     start_off,
   input  logic [BASE_W-1:0]    avail,
   output logic                 hit,
   output logic [OFF_W-1:0]     lowest
);

   logic [WORD_BITS-1:0] pattern;
   logic [WORD_BITS-1:0] window;
   logic [WORD_BITS-1:0] match;

   // Flags that equal the wanted value.
   assign pattern = find_set ? word : ~word;

   // Window: at or above the start offset and below the flags in use.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         window[b] = (OFF_W'(b) >= start_off) && (BASE_W'(b) < avail);
      end
   end

   assign match = pattern & window;
   assign hit   = |match;

   // Priority encoder: the lowest matching bit wins.
   always_comb begin
      lowest = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (match[b]) begin
            lowest = OFF_W'(b);
         end
      end
   end

endmodule

### rtl/bitmap_find_next_set_or_clear.sv
// ----------------------------------------------------------------------------
// bitmap_find_next_set_or_clear
// Occupancy bitmap with set, clear, test, all-set check and next clear or
// next set flag searches, kept in one word-wide synchronous memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap memory to zero, one word per cycle,
// over ceil(MAX_BITS / WORD_BITS) words (32 with the defaults), and stalls
// requests meanwhile; the csr port is taken at all times. One request is
// worked on at a time. Set, clear and test read the word; set and clear
// modify it and write it back. Such a request passes through the split,
// modify and response states before its response is loaded into the output
// register, and the next request is taken once the block is idle again. The
// all-set check walks the memory one word per cycle from word zero and both
// searches from the start word, through the split, scan and response states;
// the single memory read port sets that rate. A walk without a match ends
// once it runs past the flags in use.
// A new request is taken while the previous response still waits in the
// output register; a response that cannot be loaded because the one before
// it is still stalled holds the block until the output register frees up.
module bitmap_find_next_set_or_clear
   import bfns_pkg::*;
#(
   parameter int MAX_BITS  = DEF_MAX_BITS,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic               clock,
   input  logic               reset,
   // Configuration write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_bits_in_use,
   // Request channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [INDEX_W-1:0] req_index,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_flag,
   output logic [INDEX_W-1:0] rsp_position
);

   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int OFF_W      = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int CNT_W      = INDEX_W + 1;
   // Reciprocal split of the index into word and offset.
   localparam int RECIP_SHIFT = INDEX_W + 6;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
   localparam int PROD_W      = INDEX_W + RECIP_SHIFT + 1;
   localparam int LIMIT_CAP   = (MAX_BITS < LIMIT_MAX) ? MAX_BITS : LIMIT_MAX;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SPLIT  = 6'b000100,
      ST_MODIFY = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [LIMIT_W-1:0]  limit_reg_ff, limit_reg_in;
   mode_type            mode_ff, mode_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0]    word_ff, word_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic                res_flag_ff, res_flag_in;
   logic [INDEX_W-1:0]  res_pos_ff, res_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_flag_ff, rsp_flag_in;
   logic [INDEX_W-1:0]  rsp_pos_ff, rsp_pos_in;

   // Bitmap memory with registered read data.
   logic [WORD_BITS-1:0] mem_ff [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic                 req_accept;
   logic [LIMIT_W-1:0]   limit;
   logic                 idx_in_range;
   logic [CNT_W-1:0]     q_raw;
   logic [BASE_W-1:0]    r_raw;
   logic [CNT_W-1:0]     q_fix;
   logic [OFF_W-1:0]     r_fix;
   logic [BASE_W-1:0]    avail;
   logic                 scan_hit;
   logic [OFF_W-1:0]     scan_lowest;
   logic [WORD_BITS-1:0] bit_mask;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_flag     = rsp_flag_ff;
   assign rsp_position = rsp_pos_ff;

   // Effective number of flags in use, capped by the bitmap size.
   assign limit = (limit_reg_ff > LIMIT_W'(LIMIT_CAP)) ? LIMIT_W'(LIMIT_CAP) : limit_reg_ff;
   assign idx_in_range = (BASE_W'(idx_ff) < BASE_W'(limit));

   // Word and offset of the request index, with one correction step.
   assign q_raw = CNT_W'(prod_ff >> RECIP_SHIFT);
   assign r_raw = BASE_W'(idx_ff) - BASE_W'(q_raw * WORD_BITS);
   always_comb begin
      if (r_raw >= BASE_W'(WORD_BITS)) begin
         q_fix = q_raw + 1'b1;
         r_fix = OFF_W'(r_raw - BASE_W'(WORD_BITS));
      end else begin
         q_fix = q_raw;
         r_fix = OFF_W'(r_raw);
      end
   end

   // Flags left in use from the current word onward.
   assign avail = BASE_W'(limit) - base_ff;

   bfns_word_scan #(
      .WORD_BITS (WORD_BITS),
      .OFF_W     (OFF_W)
   ) u_scan (
      .word      (rd_data_ff),
      .find_set  (mode_ff == MODE_NEXT_SET),
      .start_off (off_ff),
      .avail     (avail),
      .hit       (scan_hit),
      .lowest    (scan_lowest)
   );

   assign bit_mask = WORD_BITS'(1) << off_ff;

   // Control sequencing and memory port selection.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      base_in      = base_ff;
      res_flag_in  = res_flag_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_pos_in   = rsp_pos_ff;
      rd_addr      = ADDR_W'(word_ff + 1'b1);
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(word_ff);
      wr_data      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == ADDR_W'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               mode_in  = mode_type'(req_mode);
               idx_in   = req_index;
               prod_in  = PROD_W'(req_index) * PROD_W'(RECIP);
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            res_flag_in = 1'b0;
            res_pos_in  = '0;
            word_in     = q_fix;
            off_in      = r_fix;
            base_in     = BASE_W'(q_fix * WORD_BITS);
            rd_addr     = ADDR_W'(q_fix);
            case (mode_ff)
               MODE_SET, MODE_CLEAR, MODE_TEST: begin
                  state_in = ST_MODIFY;
               end
               MODE_ALL_SET: begin
                  word_in  = '0;
                  off_in   = '0;
                  base_in  = '0;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end
               MODE_NEXT_CLEAR, MODE_NEXT_SET: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_MODIFY: begin
            state_in = ST_RESP;
            if (idx_in_range) begin
               if (mode_ff == MODE_TEST) begin
                  res_flag_in = rd_data_ff[off_ff];
               end else begin
                  res_flag_in = 1'b1;
                  wr_en       = 1'b1;
                  wr_data     = (mode_ff == MODE_SET) ? (rd_data_ff | bit_mask)
                                                      : (rd_data_ff & ~bit_mask);
               end
            end
         end
         ST_SCAN: begin
            if (base_ff >= BASE_W'(limit)) begin
               // Ran past the flags in use without a match.
               res_flag_in = (mode_ff == MODE_ALL_SET);
               state_in    = ST_RESP;
            end else if (scan_hit) begin
               if (mode_ff == MODE_ALL_SET) begin
                  res_flag_in = 1'b0;
               end else begin
                  res_flag_in = 1'b1;
                  res_pos_in  = INDEX_W'(base_ff + BASE_W'(scan_lowest));
               end
               state_in = ST_RESP;
            end else begin
               word_in = word_ff + 1'b1;
               off_in  = '0;
               base_in = base_ff + BASE_W'(WORD_BITS);
            end
         end
         ST_RESP: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = res_flag_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Flags-in-use register.
   assign limit_reg_in = (csr_valid && csr_ready) ? csr_bits_in_use : limit_reg_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         limit_reg_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         limit_reg_ff <= limit_reg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      prod_ff     <= prod_in;
      word_ff     <= word_in;
      off_ff      <= off_in;
      base_ff     <= base_in;
      res_flag_ff <= res_flag_in;
      res_pos_ff  <= res_pos_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   // Bitmap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
